// ===== rtl/phd_pkg.sv =====
// Shared constants and types for the pose heading distance pipeline.
// Used by every module under rtl except phd_out_buf; depends on nothing else.
`timescale 1ns / 1ps

package phd_pkg;

  localparam int FRACTION_BITS = 16;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_WIDE =
      (PI_Q60 + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS);
  localparam logic [63:0] TWO_PI_WIDE =
      (PI_Q60 + (64'd1 << (58 - FRACTION_BITS))) >> (59 - FRACTION_BITS);

  localparam int REM_W = 34;
  localparam logic [REM_W-1:0] PI_FIX = PI_WIDE[REM_W-1:0];
  localparam logic [REM_W-1:0] TWO_PI_FIX = TWO_PI_WIDE[REM_W-1:0];

  localparam logic [63:0] WRAP_TURNS =
      ((64'd1 << 31) + TWO_PI_WIDE - 64'd1) / TWO_PI_WIDE;
  localparam logic [63:0] BIAS_WIDE = PI_WIDE + WRAP_TURNS * TWO_PI_WIDE;
  localparam logic [REM_W-1:0] WRAP_BIAS = BIAS_WIDE[REM_W-1:0];
  localparam int WRAP_STEPS =
      $clog2(((64'd1 << 33) + TWO_PI_WIDE - 64'd1) / TWO_PI_WIDE);

  localparam int COORD_W = 32;
  localparam int SQ_W = 64;
  localparam int ROOT_W = 32;
  localparam int SQRT_STEPS = 32;
  localparam int WEIGHT_W = 16;
  localparam int ANG_W = FRACTION_BITS + 2;
  localparam int PROD_W = ANG_W + WEIGHT_W;
  localparam int FINAL_W = (PROD_W > 32) ? PROD_W + 1 : 34;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(128);

  typedef struct packed {
    logic [SQ_W-1:0]  op;
    logic [SQ_W-1:0]  res;
    logic [REM_W-1:0] rem_a;
    logic [REM_W-1:0] rem_b;
    logic             sat;
  } cell_t;

endpackage

// ===== rtl/phd_front.sv =====
// Front stages: coordinate differences, squares and their sum, heading bias.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic signed [phd_pkg::COORD_W-1:0] first_x,
  input  logic signed [phd_pkg::COORD_W-1:0] first_y,
  input  logic signed [phd_pkg::COORD_W-1:0] first_z,
  input  logic signed [phd_pkg::COORD_W-1:0] first_heading,
  input  logic signed [phd_pkg::COORD_W-1:0] second_x,
  input  logic signed [phd_pkg::COORD_W-1:0] second_y,
  input  logic signed [phd_pkg::COORD_W-1:0] second_z,
  input  logic signed [phd_pkg::COORD_W-1:0] second_heading,
  output phd_pkg::cell_t                 front_data,
  output logic                           front_valid
);

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    logic [32:0] n;
    d = {a[31], a} - {b[31], b};
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  function automatic logic [phd_pkg::REM_W-1:0] bias_heading(input logic [31:0] h);
    return {{(phd_pkg::REM_W - 32){h[31]}}, h} + phd_pkg::WRAP_BIAS;
  endfunction

  logic [31:0] dx, dy, dz;
  logic [phd_pkg::REM_W-1:0] ha1, hb1, ha2, hb2, ha3, hb3;
  logic [phd_pkg::SQ_W-1:0] sqx, sqy, sqz;
  logic [phd_pkg::SQ_W+1:0] sum_wide;
  logic [phd_pkg::SQ_W-1:0] sum3;
  logic sat3;
  logic valid1, valid2, valid3;

  assign sum_wide = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (adv) begin
      valid1 <= in_valid;
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx <= abs_diff(first_x, second_x);
      dy <= abs_diff(first_y, second_y);
      dz <= abs_diff(first_z, second_z);
      ha1 <= bias_heading(first_heading);
      hb1 <= bias_heading(second_heading);
      sqx <= phd_pkg::SQ_W'(dx) * phd_pkg::SQ_W'(dx);
      sqy <= phd_pkg::SQ_W'(dy) * phd_pkg::SQ_W'(dy);
      sqz <= phd_pkg::SQ_W'(dz) * phd_pkg::SQ_W'(dz);
      ha2 <= ha1;
      hb2 <= hb1;
      sum3 <= sum_wide[phd_pkg::SQ_W-1:0];
      sat3 <= sum_wide[phd_pkg::SQ_W+1:phd_pkg::SQ_W] != 2'b00;
      ha3 <= ha2;
      hb3 <= hb2;
    end
  end

  always_comb begin
    front_data.op = sum3;
    front_data.res = '0;
    front_data.rem_a = ha3;
    front_data.rem_b = hb3;
    front_data.sat = sat3;
  end

  assign front_valid = valid3;

endmodule

// ===== rtl/phd_cell.sv =====
// One cell of the chain: a square root digit step and a heading reduction step.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [phd_pkg::SQ_W-1:0]      one_bit,
  input  logic [phd_pkg::REM_W-1:0]     wrap_step,
  input  phd_pkg::cell_t                cell_in,
  input  logic                          valid_in,
  output phd_pkg::cell_t                cell_out,
  output logic                          valid_out
);

  logic [phd_pkg::SQ_W:0] trial;
  logic fits;
  phd_pkg::cell_t cell_next;

  assign trial = {1'b0, cell_in.res} + {1'b0, one_bit};
  assign fits = {1'b0, cell_in.op} >= trial;

  always_comb begin
    cell_next = cell_in;
    if (fits) begin
      cell_next.op = cell_in.op - trial[phd_pkg::SQ_W-1:0];
      cell_next.res = (cell_in.res >> 1) + one_bit;
    end else begin
      cell_next.res = cell_in.res >> 1;
    end
    if (cell_in.rem_a >= wrap_step) begin
      cell_next.rem_a = cell_in.rem_a - wrap_step;
    end
    if (cell_in.rem_b >= wrap_step) begin
      cell_next.rem_b = cell_in.rem_b - wrap_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_out <= cell_next;
    end
  end

endmodule

// ===== rtl/phd_back.sv =====
// Back stages: angle fold, weighting, final sum and saturation.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic [phd_pkg::WEIGHT_W-1:0]     weight,
  input  phd_pkg::cell_t                   cell_in,
  input  logic                             valid_in,
  output logic [31:0]                      result,
  output logic                             result_valid
);

  logic [phd_pkg::REM_W-1:0] ad, folded;
  logic [phd_pkg::ANG_W-1:0] ang1;
  logic [phd_pkg::ROOT_W-1:0] root1, root2;
  logic sat1, sat2, valid1, valid2;
  logic [phd_pkg::PROD_W-1:0] prod2;
  logic [phd_pkg::PROD_W:0] rounded;
  logic [phd_pkg::FINAL_W-1:0] total;

  always_comb begin
    if (cell_in.rem_a >= cell_in.rem_b) begin
      ad = cell_in.rem_a - cell_in.rem_b;
    end else begin
      ad = cell_in.rem_b - cell_in.rem_a;
    end
    if (ad > phd_pkg::PI_FIX) begin
      folded = phd_pkg::TWO_PI_FIX - ad;
    end else begin
      folded = ad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else if (adv) begin
      valid1 <= valid_in;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang1 <= folded[phd_pkg::ANG_W-1:0];
      root1 <= cell_in.res[phd_pkg::ROOT_W-1:0];
      sat1 <= cell_in.sat;
      prod2 <= phd_pkg::PROD_W'(ang1) * phd_pkg::PROD_W'(weight);
      root2 <= root1;
      sat2 <= sat1;
    end
  end

  assign rounded = {1'b0, prod2} + phd_pkg::ROUND_HALF;
  assign total = phd_pkg::FINAL_W'(root2) + phd_pkg::FINAL_W'(rounded[phd_pkg::PROD_W:8]);
  assign result = (sat2 || total[phd_pkg::FINAL_W-1:32] != '0) ? 32'hFFFF_FFFF : total[31:0];
  assign result_valid = valid2;

endmodule

// ===== rtl/phd_out_buf.sv =====
// Output register with one skid entry; it also drives the pipeline advance.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module phd_out_buf (
  input  logic        clk,
  input  logic        rst,
  input  logic        pipe_valid,
  input  logic [31:0] pipe_data,
  output logic        adv,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pose_distance
);

  logic skid_valid;
  logic [31:0] skid_data;
  logic take, incoming;

  assign adv = !skid_valid;
  assign take = out_valid && !out_stall;
  assign incoming = pipe_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        pose_distance <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid || take) begin
        pose_distance <= pipe_data;
        out_valid <= 1'b1;
      end else begin
        skid_data <= pipe_data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/pose_heading_distance.sv =====
// Top level of the pose heading distance metric: front stages, cell chain,
// back stages and output buffer. Depends on phd_pkg and all phd_* modules.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid, in_stall   | first_* and second_* x, y, z, heading
//   out      | out_valid, out_stall | pose_distance
//   cfg      | cfg_valid, cfg_ready | cfg_data (angular_weight)
//
// One request is accepted per cycle while in_stall is low; its result passes
// through three front stages, the 32 cells of the square root chain, two back
// stages and the output register, the first front stage loading at the
// accepting edge. Reset empties the pipeline and sets the weight to 1.0.
// in_stall rises only while the skid entry holds a result, which freezes
// the whole pipeline until the output register drains.
`timescale 1ns / 1ps

module pose_heading_distance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [phd_pkg::COORD_W-1:0]  first_x,
  input  logic signed [phd_pkg::COORD_W-1:0]  first_y,
  input  logic signed [phd_pkg::COORD_W-1:0]  first_z,
  input  logic signed [phd_pkg::COORD_W-1:0]  first_heading,
  input  logic signed [phd_pkg::COORD_W-1:0]  second_x,
  input  logic signed [phd_pkg::COORD_W-1:0]  second_y,
  input  logic signed [phd_pkg::COORD_W-1:0]  second_z,
  input  logic signed [phd_pkg::COORD_W-1:0]  second_heading,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [31:0]                         pose_distance,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [phd_pkg::WEIGHT_W-1:0]        cfg_data
);

  logic adv;
  logic [phd_pkg::WEIGHT_W-1:0] angular_weight;
  phd_pkg::cell_t chain [0:phd_pkg::SQRT_STEPS];
  logic chain_valid [0:phd_pkg::SQRT_STEPS];
  logic [31:0] result;
  logic result_valid;

  assign cfg_ready = 1'b1;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      angular_weight <= phd_pkg::WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      angular_weight <= cfg_data;
    end
  end

  phd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (in_valid),
    .first_x        (first_x),
    .first_y        (first_y),
    .first_z        (first_z),
    .first_heading  (first_heading),
    .second_x       (second_x),
    .second_y       (second_y),
    .second_z       (second_z),
    .second_heading (second_heading),
    .front_data     (chain[0]),
    .front_valid    (chain_valid[0])
  );

  for (genvar k = 0; k < phd_pkg::SQRT_STEPS; k++) begin : g_cell
    localparam logic [phd_pkg::SQ_W-1:0] ONE_BIT =
        phd_pkg::SQ_W'(1) << (2 * (phd_pkg::SQRT_STEPS - 1 - k));
    localparam logic [phd_pkg::REM_W-1:0] WRAP_STEP = (k < phd_pkg::WRAP_STEPS) ?
        (phd_pkg::TWO_PI_FIX << (phd_pkg::WRAP_STEPS - 1 - k)) : '0;

    phd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .one_bit   (ONE_BIT),
      .wrap_step (WRAP_STEP),
      .cell_in   (chain[k]),
      .valid_in  (chain_valid[k]),
      .cell_out  (chain[k+1]),
      .valid_out (chain_valid[k+1])
    );
  end

  phd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .weight       (angular_weight),
    .cell_in      (chain[phd_pkg::SQRT_STEPS]),
    .valid_in     (chain_valid[phd_pkg::SQRT_STEPS]),
    .result       (result),
    .result_valid (result_valid)
  );

  phd_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .pipe_valid    (result_valid),
    .pipe_data     (result),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pose_distance (pose_distance)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for pose_heading_distance: directed rows, then random pose pairs
// checked against a predictor of the weighted position plus heading distance.
// Depends on rtl/phd_pkg.sv and rtl/pose_heading_distance.sv.
`timescale 1ns / 1ps

module testbench;

  localparam longint HALF_TURN = 64'd205887;
  localparam longint FULL_TURN = 64'd411775;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 48;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [phd_pkg::COORD_W-1:0] first_x;
    logic signed [phd_pkg::COORD_W-1:0] first_y;
    logic signed [phd_pkg::COORD_W-1:0] first_z;
    logic signed [phd_pkg::COORD_W-1:0] first_heading;
    logic signed [phd_pkg::COORD_W-1:0] second_x;
    logic signed [phd_pkg::COORD_W-1:0] second_y;
    logic signed [phd_pkg::COORD_W-1:0] second_z;
    logic signed [phd_pkg::COORD_W-1:0] second_heading;
  } pose_pair_t;

  typedef struct {
    pose_pair_t  poses;
    bit          typed;
    logic [31:0] distance;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [phd_pkg::COORD_W-1:0] first_x = '0;
  logic signed [phd_pkg::COORD_W-1:0] first_y = '0;
  logic signed [phd_pkg::COORD_W-1:0] first_z = '0;
  logic signed [phd_pkg::COORD_W-1:0] first_heading = '0;
  logic signed [phd_pkg::COORD_W-1:0] second_x = '0;
  logic signed [phd_pkg::COORD_W-1:0] second_y = '0;
  logic signed [phd_pkg::COORD_W-1:0] second_z = '0;
  logic signed [phd_pkg::COORD_W-1:0] second_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] pose_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [phd_pkg::WEIGHT_W-1:0] cfg_data = '0;

  logic [31:0] pending_distances[$];
  directed_row_t directed_rows[$];
  logic [phd_pkg::WEIGHT_W-1:0] weight_setting = phd_pkg::WEIGHT_RESET;
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_outputs = 1'b0;

  pose_heading_distance i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_x        (first_x),
    .first_y        (first_y),
    .first_z        (first_z),
    .first_heading  (first_heading),
    .second_x       (second_x),
    .second_y       (second_y),
    .second_z       (second_z),
    .second_heading (second_heading),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pose_distance  (pose_distance),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint wrap_heading(logic signed [31:0] heading);
    longint shifted;
    longint turns_rem;
    shifted = longint'(heading) + HALF_TURN;
    turns_rem = shifted % FULL_TURN;
    if (turns_rem < 0) begin
      turns_rem += FULL_TURN;
    end
    return turns_rem - HALF_TURN;
  endfunction

  function automatic logic [31:0] predict_pose_distance(pose_pair_t p, logic [15:0] weight);
    logic signed [31:0] lhs [3];
    logic signed [31:0] rhs [3];
    longint diff;
    longint angle;
    logic [65:0] mag;
    logic [65:0] sum_sq;
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    logic [63:0] weighted;
    logic [64:0] total;
    lhs[0] = p.first_x;
    lhs[1] = p.first_y;
    lhs[2] = p.first_z;
    rhs[0] = p.second_x;
    rhs[1] = p.second_y;
    rhs[2] = p.second_z;
    sum_sq = '0;
    for (int axis = 0; axis < 3; axis++) begin
      diff = longint'(lhs[axis]) - longint'(rhs[axis]);
      if (diff < 0) begin
        diff = -diff;
      end
      mag = 66'(diff);
      sum_sq += mag * mag;
    end
    rem = sum_sq[63:0];
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) begin
      probe >>= 2;
    end
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    angle = wrap_heading(p.first_heading) - wrap_heading(p.second_heading);
    if (angle < 0) begin
      angle = -angle;
    end
    if (angle > HALF_TURN) begin
      angle = FULL_TURN - angle;
    end
    weighted = (64'(angle) * 64'(weight) + 64'd128) >> 8;
    total = 65'(root) + 65'(weighted);
    if (sum_sq[65:64] != 2'b00 || total > 65'h0_FFFF_FFFF) begin
      return 32'hFFFF_FFFF;
    end
    return total[31:0];
  endfunction

  function automatic pose_pair_t random_pose_pair();
    logic [31:0] corners [5];
    logic [31:0] f [4];
    logic [31:0] s [4];
    int shape;
    int turns;
    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      f[i] = $urandom;
      s[i] = $urandom;
      if (shape <= 3 && i < 3) begin
        s[i] = f[i] + ($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
      end else if (shape == 7) begin
        f[i] = corners[$urandom_range(0, 4)];
        s[i] = corners[$urandom_range(0, 4)];
      end else if (shape >= 8 && i < 3) begin
        f[i] = $signed(f[i]) >>> 10;
        s[i] = $signed(s[i]) >>> 10;
      end
    end
    if (shape <= 1 || shape == 8) begin
      turns = int'($urandom_range(0, 20)) - 10;
      f[3] = 32'(longint'(turns) * HALF_TURN) + ($urandom_range(0, 8) - 4);
      turns = int'($urandom_range(0, 20)) - 10;
      s[3] = 32'(longint'(turns) * HALF_TURN) + ($urandom_range(0, 8) - 4);
    end
    return '{f[0], f[1], f[2], f[3], s[0], s[1], s[2], s[3]};
  endfunction

  function automatic void add_row(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                                  logic [31:0] fh, logic [31:0] sx, logic [31:0] sy,
                                  logic [31:0] sz, logic [31:0] sh, bit typed,
                                  logic [31:0] distance);
    directed_row_t row;
    row.poses = '{fx, fy, fz, fh, sx, sy, sz, sh};
    row.typed = typed;
    row.distance = distance;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s, pose_distance %h, expected %h", $time, what, got, want);
  endtask

  // Called at a rising edge; returns at the rising edge where the request is taken.
  task automatic send_pose_pair(pose_pair_t p, logic [31:0] distance);
    int gap;
    bit took;
    gap = sender_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    first_x <= p.first_x;
    first_y <= p.first_y;
    first_z <= p.first_z;
    first_heading <= p.first_heading;
    second_x <= p.second_x;
    second_y <= p.second_y;
    second_z <= p.second_z;
    second_heading <= p.second_heading;
    do begin
      @(negedge clk);
      took = !in_stall;
      if (took) begin
        pending_distances.push_back(distance);
      end
      @(posedge clk);
    end while (!took);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_distances.size() != 0);
  endtask

  task automatic write_weight(logic [phd_pkg::WEIGHT_W-1:0] weight);
    bit took;
    cfg_valid <= 1'b1;
    cfg_data <= weight;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    weight_setting = weight;
  endtask

  initial begin
    int n;
    bit took;
    @(posedge clk);
    forever begin
      n = receiver_idle ? $urandom_range(0, 6) : 0;
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_distances.size() == 0) begin
        report_mismatch("result with no request waiting", pose_distance, 'x);
      end else if (pose_distance !== pending_distances[0]) begin
        report_mismatch("wrong distance", pose_distance, pending_distances.pop_front());
      end else begin
        void'(pending_distances.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [phd_pkg::WEIGHT_W-1:0] weights [6];
    pose_pair_t p;
    weights = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), phd_pkg::WEIGHT_RESET};

    add_row('0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 32'h0000_0000);
    add_row(32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0, '0, 1'b1, 32'h0005_0000);
    add_row(32'h7FFF_FFFF, '0, '0, '0, 32'h8000_0000, '0, '0, '0, 1'b1, 32'hFFFF_FFFF);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0,
            1'b1, 32'hFFFF_FFFF);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, '0, 1'b1, 32'hFFFF_FFFF);
    add_row('0, '0, '0, '0, '0, '0, '0, 32'h0003_243F, 1'b1, 32'h0003_243F);
    add_row('0, '0, '0, 32'h0003_243F, '0, '0, '0, 32'hFFFC_DBC1, 1'b0, '0);
    add_row('0, '0, '0, 32'h7FFF_FFFF, '0, '0, '0, 32'h8000_0000, 1'b0, '0);
    add_row('0, '0, '0, '0, '0, '0, '0, 32'h0003_2440, 1'b0, '0);
    add_row('0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000);
    add_row(32'h7FFF_FFFF, '0, '0, '0, 32'h8000_0000, '0, '0, 32'h0003_243F,
            1'b1, 32'hFFFF_FFFF);
    add_row('0, '0, 32'h0000_0001, '0, '0, '0, '0, '0, 1'b1, 32'h0000_0001);
    add_row('0, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b1, 32'h0000_0001);
    add_row(32'hFFFB_0000, '0, 32'h0005_0000, '0, 32'h0007_0000, '0, '0, '0,
            1'b1, 32'h000D_0000);
    add_row('0, '0, '0, 32'h0010_0000, '0, '0, '0, 32'h8000_0000, 1'b0, '0);
    add_row('0, '0, '0, 32'h0006_487F, '0, '0, '0, '0, 1'b0, '0);
    add_row('0, '0, '0, 32'hFFFC_DBC0, '0, '0, '0, 32'h0003_243F, 1'b0, '0);
    add_row(32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h5555_AAAA, 32'h1234_0000,
            32'hDEAD_0000, 32'h0BAD_0000, 32'hAAAA_5555, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_pose_pair(directed_rows[i].poses, directed_rows[i].typed ? directed_rows[i].distance
                     : predict_pose_distance(directed_rows[i].poses, weight_setting));
    end

    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      write_weight(weights[phase]);
      sender_idle = (phase != 1 && phase != 2 && phase != 5);
      receiver_idle = (phase != 2 && phase != 4);
      hold_outputs = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        p = random_pose_pair();
        send_pose_pair(p, predict_pose_distance(p, weight_setting));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
